### rtl/core/rmts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rmts_pkg;

  // Default sizes of the scheduler.
  localparam int QueueDepthDef   = 8;
  localparam int RunSlotsDef     = 4;
  localparam int ResourceBitsDef = 8;

  // Kinds of reported events.
  typedef enum logic [2:0] {
    EV_QUEUED   = 3'd0,
    EV_REJECTED = 3'd1,
    EV_STARTED  = 3'd2,
    EV_FINISHED = 3'd3,
    EV_PASS_END = 3'd4
  } ev_kind_t;

  // Actions of one command.
  typedef enum logic {
    ACT_SUBMIT = 1'b0,
    ACT_RUN    = 1'b1
  } action_t;

  typedef struct packed {
    action_t     action;
    logic [7:0]  task_tag;
    logic [7:0]  needs_mask;
    logic [3:0]  done_mask;
  } cmd_t;

  typedef struct packed {
    ev_kind_t    event_kind;
    logic [2:0]  queue_slot;
    logic [1:0]  run_slot;
    logic [7:0]  event_tag;
    logic [7:0]  busy_now;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

### rtl/core/rmts_queue.sv
`timescale 1ns / 1ps
`default_nettype none

// Task queue: a valid bit per slot in flip-flops, and the tag and resource
// mask of each slot in a small memory with one write port and one
// registered read port.
module rmts_queue #(
  parameter int QUEUE_DEPTH   = rmts_pkg::QueueDepthDef,
  parameter int RESOURCE_BITS = rmts_pkg::ResourceBitsDef,
  parameter int QIW           = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     wr_en,
  input  wire logic [QIW-1:0]           wr_idx,
  input  wire logic [7:0]               wr_tag,
  input  wire logic [RESOURCE_BITS-1:0] wr_needs,
  input  wire logic                     clr_en,
  input  wire logic [QIW-1:0]           clr_idx,
  input  wire logic [QIW-1:0]           rd_idx,
  output logic      [QUEUE_DEPTH-1:0]   valid_vec,
  output logic      [7:0]               rd_tag,
  output logic      [RESOURCE_BITS-1:0] rd_needs
);

  logic [7:0]               tag_mem   [QUEUE_DEPTH];
  logic [RESOURCE_BITS-1:0] needs_mem [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_vec <= '0;
    end else begin
      if (wr_en) begin
        valid_vec[wr_idx] <= 1'b1;
      end
      if (clr_en) begin
        valid_vec[clr_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tag_mem[wr_idx]   <= wr_tag;
      needs_mem[wr_idx] <= wr_needs;
    end
    rd_tag   <= tag_mem[rd_idx];
    rd_needs <= needs_mem[rd_idx];
  end

endmodule

`default_nettype wire

### rtl/core/resource_mask_task_scheduler_core.sv
`timescale 1ns / 1ps
`default_nettype none

// A submit gives a single result; a run pass gives its start and finish results and ends with
// its pass-done result, its length set by the queue scan with its registered memory read per
// slot and by the walk of the run slots.
// Throughput: one command at a time; busy stays high until the last result is driven.
// The receiver cannot stall: each result is on the result port for one cycle, marked by
// result_valid. Reset (rst, synchronous, active high) empties the queue and the run slots.
module resource_mask_task_scheduler_core #(
  parameter int QUEUE_DEPTH   = rmts_pkg::QueueDepthDef,
  parameter int RUN_SLOTS     = rmts_pkg::RunSlotsDef,
  parameter int RESOURCE_BITS = rmts_pkg::ResourceBitsDef
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire rmts_pkg::cmd_t    cmd,
  output logic                   busy,
  output logic                   result_valid,
  output rmts_pkg::result_t      result
);

  // Index widths, and counter widths that can also hold the depth itself.
  localparam int QIW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int RIW = (RUN_SLOTS > 1) ? $clog2(RUN_SLOTS) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int RCW = $clog2(RUN_SLOTS + 1);

  // The sequencer. A submit walks the queue valid bits until it finds a free
  // slot, or rejects the task if none is. A run pass first reads each queue
  // slot (ST_QRD addresses the memory, ST_QEV evaluates), then walks the run
  // slots to retire the finished tasks, and finally reports the end of the pass.
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SUB  = 5'b00010,
    ST_QRD  = 5'b00100,
    ST_QEV  = 5'b01000,
    ST_RUN  = 5'b10000
  } state_t;

  state_t                   state, state_next;
  rmts_pkg::cmd_t           cmd_q, cmd_q_next;
  logic [QCW-1:0]           qcnt, qcnt_next;
  logic [RCW-1:0]           rcnt, rcnt_next;
  logic [RESOURCE_BITS-1:0] busy_mask, busy_mask_next;
  logic [RUN_SLOTS-1:0]     run_valid, run_valid_next;
  logic [7:0]               run_tag   [RUN_SLOTS];
  logic [RESOURCE_BITS-1:0] run_needs [RUN_SLOTS];
  logic                     result_valid_next;
  rmts_pkg::result_t        result_next;

  // Queue interface.
  logic                     q_wr_en;
  logic                     q_clr_en;
  logic [QUEUE_DEPTH-1:0]   q_valid;
  logic [7:0]               q_rd_tag;
  logic [RESOURCE_BITS-1:0] q_rd_needs;
  logic [RESOURCE_BITS-1:0] needs_in;

  // Run slot writes at a task start.
  logic                     run_wr_en;

  logic [QIW-1:0]           qidx;
  logic [RIW-1:0]           ridx;
  logic [RIW-1:0]           free_idx;
  logic                     free_any;
  logic [31:0]              qidx_w;
  logic [31:0]              ridx_w;
  logic [31:0]              free_w;
  logic [31:0]              rcnt_w;
  logic [39:0]              needs_w;
  logic [39:0]              busy_w;
  logic                     done_bit;

  assign qidx    = qcnt[QIW-1:0];
  assign ridx    = rcnt[RIW-1:0];
  assign qidx_w  = 32'(qidx);
  assign ridx_w  = 32'(ridx);
  assign free_w  = 32'(free_idx);
  assign rcnt_w  = 32'(rcnt);
  assign needs_w = 40'(cmd_q.needs_mask);
  assign needs_in = needs_w[RESOURCE_BITS-1:0];
  assign busy_w  = 40'(busy_mask_next);

  // Only four done bits exist; run slots beyond them never report done.
  assign done_bit = (rcnt_w < 32'd4) ? cmd_q.done_mask[rcnt_w[1:0]] : 1'b0;

  assign busy = (state != ST_IDLE);

  // Lowest free run slot.
  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = RUN_SLOTS - 1; i >= 0; i--) begin
      if (!run_valid[i]) begin
        free_idx = RIW'(i);
        free_any = 1'b1;
      end
    end
  end

  rmts_queue #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .RESOURCE_BITS (RESOURCE_BITS),
    .QIW           (QIW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (q_wr_en),
    .wr_idx    (qidx),
    .wr_tag    (cmd_q.task_tag),
    .wr_needs  (needs_in),
    .clr_en    (q_clr_en),
    .clr_idx   (qidx),
    .rd_idx    (qidx),
    .valid_vec (q_valid),
    .rd_tag    (q_rd_tag),
    .rd_needs  (q_rd_needs)
  );

  always_comb begin
    state_next        = state;
    cmd_q_next        = cmd_q;
    qcnt_next         = qcnt;
    rcnt_next         = rcnt;
    busy_mask_next    = busy_mask;
    run_valid_next    = run_valid;
    q_wr_en           = 1'b0;
    q_clr_en          = 1'b0;
    run_wr_en         = 1'b0;
    result_valid_next = 1'b0;
    result_next       = result;

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd_q_next = cmd;
          qcnt_next  = '0;
          rcnt_next  = '0;
          state_next = (cmd.action == rmts_pkg::ACT_SUBMIT) ? ST_SUB : ST_QRD;
        end
      end

      ST_SUB: begin
        if (qcnt == QCW'(QUEUE_DEPTH)) begin
          // Every slot is taken: the submitted task is dropped.
          result_valid_next      = 1'b1;
          result_next.event_kind = rmts_pkg::EV_REJECTED;
          result_next.queue_slot = '0;
          result_next.run_slot   = '0;
          result_next.event_tag  = cmd_q.task_tag;
          result_next.busy_now   = busy_w[7:0];
          result_next.last       = 1'b1;
          state_next             = ST_IDLE;
        end else if (!q_valid[qidx]) begin
          q_wr_en                = 1'b1;
          result_valid_next      = 1'b1;
          result_next.event_kind = rmts_pkg::EV_QUEUED;
          result_next.queue_slot = qidx_w[2:0];
          result_next.run_slot   = '0;
          result_next.event_tag  = cmd_q.task_tag;
          result_next.busy_now   = busy_w[7:0];
          result_next.last       = 1'b1;
          state_next             = ST_IDLE;
        end else begin
          qcnt_next = qcnt + 1'b1;
        end
      end

      ST_QRD: begin
        // The queue memory is addressed by qidx; its data is ready next cycle.
        if (qcnt == QCW'(QUEUE_DEPTH)) begin
          state_next = ST_RUN;
        end else begin
          state_next = ST_QEV;
        end
      end

      ST_QEV: begin
        // A queued task starts when it needs nothing that is busy and a
        // run slot is free; otherwise it stays queued and the scan goes on.
        if (q_valid[qidx] && ((q_rd_needs & busy_mask) == '0) && free_any) begin
          q_clr_en                 = 1'b1;
          run_wr_en                = 1'b1;
          run_valid_next[free_idx] = 1'b1;
          busy_mask_next           = busy_mask | q_rd_needs;
          result_valid_next        = 1'b1;
          result_next.event_kind   = rmts_pkg::EV_STARTED;
          result_next.queue_slot   = qidx_w[2:0];
          result_next.run_slot     = free_w[1:0];
          result_next.event_tag    = q_rd_tag;
          result_next.busy_now     = busy_w[7:0];
          result_next.last         = 1'b0;
        end
        qcnt_next  = qcnt + 1'b1;
        state_next = ST_QRD;
      end

      ST_RUN: begin
        if (rcnt == RCW'(RUN_SLOTS)) begin
          result_valid_next      = 1'b1;
          result_next.event_kind = rmts_pkg::EV_PASS_END;
          result_next.queue_slot = '0;
          result_next.run_slot   = '0;
          result_next.event_tag  = '0;
          result_next.busy_now   = busy_w[7:0];
          result_next.last       = 1'b1;
          state_next             = ST_IDLE;
        end else begin
          // A done bit on an empty run slot is ignored.
          if (run_valid[ridx] && done_bit) begin
            run_valid_next[ridx]   = 1'b0;
            busy_mask_next         = busy_mask & ~run_needs[ridx];
            result_valid_next      = 1'b1;
            result_next.event_kind = rmts_pkg::EV_FINISHED;
            result_next.queue_slot = '0;
            result_next.run_slot   = ridx_w[1:0];
            result_next.event_tag  = run_tag[ridx];
            result_next.busy_now   = busy_w[7:0];
            result_next.last       = 1'b0;
          end
          rcnt_next = rcnt + 1'b1;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      busy_mask    <= '0;
      run_valid    <= '0;
      result_valid <= 1'b0;
      qcnt         <= '0;
      rcnt         <= '0;
    end else begin
      state        <= state_next;
      busy_mask    <= busy_mask_next;
      run_valid    <= run_valid_next;
      result_valid <= result_valid_next;
      qcnt         <= qcnt_next;
      rcnt         <= rcnt_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmd_q  <= cmd_q_next;
    result <= result_next;
    if (run_wr_en) begin
      run_tag[free_idx]   <= q_rd_tag;
      run_needs[free_idx] <= q_rd_needs;
    end
  end

endmodule

`default_nettype wire
